[hdl/mersenne_twister_64_generator_defines.svh]
`ifndef MERSENNE_TWISTER_64_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_64_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define MT64_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define MT64_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mt64_pkg.sv]
`timescale 1ns / 1ps

package mt64_pkg;

    localparam int STATE_WORDS   = 312;
    localparam int MIDDLE_OFFSET = 156;
    localparam int WORD_BITS     = 64;
    localparam int ADDR_BITS     = $clog2(STATE_WORDS + 2);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [31:0]          half_t;

    localparam word_t TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
    localparam word_t SEED_MULT    = 64'd6364136223846793005;
    localparam word_t DEFAULT_SEED = 64'd5489;
    localparam int    LOWER_BITS   = 31;

    localparam addr_t LAST_WORD    = addr_t'(STATE_WORDS - 1);
    localparam addr_t MIDDLE_ADDR  = addr_t'(MIDDLE_OFFSET);
    localparam addr_t USED_UP      = addr_t'(STATE_WORDS);
    localparam addr_t NEVER_SEEDED = addr_t'(STATE_WORDS + 1);

    localparam logic FUNC_SEED    = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    function automatic word_t temper(input word_t w);
        word_t y;
        y = w;
        y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
        y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
        y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
        y = y ^ (y >> 43);
        return y;
    endfunction

endpackage

[hdl/mt64_req_if.sv]
`timescale 1ns / 1ps

interface mt64_req_if import mt64_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  func;
    word_t seed_value;

    modport source (output valid, output func, output seed_value, input ready);
    modport sink   (input valid, input func, input seed_value, output ready);
endinterface

[hdl/mt64_rsp_if.sv]
`timescale 1ns / 1ps

interface mt64_rsp_if import mt64_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

[hdl/mersenne_twister_64_generator.sv]
`timescale 1ns / 1ps
// Channel | Dir | Payload                  | Handshake
// req     | in  | func, seed_value         | valid/ready
// rsp     | out | random_word              | valid/ready, output register
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Seed: M0..M3 per word, bound by the shared 32x32 multiplier (three products per word).
// Twist: a priming read, then one word per read/write pair on the 312 x 64 state memory.
// Extract from a twisted state: EX_RD, EX_OUT; with no seed it also seeds and twists first.
// Reset clears the control state only; the state memory is never read before a seed fills it.
// A result held on rsp does not block req; the next extract waits only if rsp is still full.

`include "mersenne_twister_64_generator_defines.svh"

module mersenne_twister_64_generator import mt64_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    mt64_req_if.sink   req,
    mt64_rsp_if.source rsp
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SEED_M0  = 4'd1;
    localparam logic [3:0] ST_SEED_M1  = 4'd2;
    localparam logic [3:0] ST_SEED_M2  = 4'd3;
    localparam logic [3:0] ST_SEED_M3  = 4'd4;
    localparam logic [3:0] ST_TW_PRIME = 4'd5;
    localparam logic [3:0] ST_TW_RD    = 4'd6;
    localparam logic [3:0] ST_TW_WR    = 4'd7;
    localparam logic [3:0] ST_EX_RD    = 4'd8;
    localparam logic [3:0] ST_EX_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;
    addr_t      index_reg, index_next;
    addr_t      cnt_reg, cnt_next;
    logic       extract_reg, extract_next;
    word_t      prev_reg, prev_next;
    word_t      carry_reg, carry_next;
    word_t      acc_reg, acc_next;
    word_t      mul_reg, mul_next;
    logic       out_valid_reg, out_valid_next;
    word_t      out_word_reg, out_word_next;

    word_t state_mem [STATE_WORDS];
    word_t rd_a_q;
    word_t rd_b_q;
    logic  rd_en;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    logic  mem_we;
    addr_t mem_waddr;
    word_t mem_wdata;

    half_t mul_a;
    half_t mul_b;
    word_t mul_res;
    word_t seed_mix;
    word_t twist_x;
    word_t twist_v;
    addr_t cnt_plus1;
    addr_t addr_succ;
    addr_t addr_mid;
    logic  req_fire;
    logic  out_free;

    assign req.ready       = (state_reg == ST_IDLE);
    assign req_fire        = req.valid && req.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.random_word = out_word_reg;
    assign out_free        = !out_valid_reg || rsp.ready;

    assign cnt_plus1 = cnt_reg + addr_t'(1);
    assign addr_succ = (cnt_reg == LAST_WORD) ? '0 : cnt_plus1;
    assign addr_mid  = (cnt_reg >= MIDDLE_ADDR) ? (cnt_reg - MIDDLE_ADDR)
                                                : (cnt_reg + MIDDLE_ADDR);

    assign seed_mix = prev_reg ^ (prev_reg >> (WORD_BITS - 2));
    assign mul_res  = mul_a * mul_b;

    assign twist_x = {carry_reg[WORD_BITS-1:LOWER_BITS], rd_a_q[LOWER_BITS-1:0]};
    assign twist_v = (twist_x >> 1) ^ (twist_x[0] ? TWIST_MATRIX : '0);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            state_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_q <= state_mem[rd_addr_a];
            rd_b_q <= state_mem[rd_addr_b];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        index_next     = index_reg;
        cnt_next       = cnt_reg;
        extract_next   = extract_reg;
        prev_next      = prev_reg;
        carry_next     = carry_reg;
        acc_next       = acc_reg;
        mul_next       = mul_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = prev_reg;
        rd_en     = 1'b0;
        rd_addr_a = addr_succ;
        rd_addr_b = addr_mid;
        mul_a     = seed_mix[31:0];
        mul_b     = SEED_MULT[31:0];

        // drop the held result once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    cnt_next = addr_t'(1);
                    if (req.func == FUNC_SEED)
                    begin
                        mem_we       = 1'b1;
                        mem_waddr    = '0;
                        mem_wdata    = req.seed_value;
                        prev_next    = req.seed_value;
                        extract_next = 1'b0;
                        state_next   = ST_SEED_M0;
                    end
                    else if (index_reg == NEVER_SEEDED)
                    begin
                        mem_we       = 1'b1;
                        mem_waddr    = '0;
                        mem_wdata    = DEFAULT_SEED;
                        prev_next    = DEFAULT_SEED;
                        extract_next = 1'b1;
                        state_next   = ST_SEED_M0;
                    end
                    else if (index_reg == USED_UP)
                    begin
                        state_next = ST_TW_PRIME;
                    end
                    else
                    begin
                        state_next = ST_EX_RD;
                    end
                end
            end
            ST_SEED_M0:
            begin
                mul_a      = seed_mix[31:0];
                mul_b      = SEED_MULT[31:0];
                mul_next   = mul_res;
                state_next = ST_SEED_M1;
            end
            ST_SEED_M1:
            begin
                mul_a      = seed_mix[63:32];
                mul_b      = SEED_MULT[31:0];
                acc_next   = mul_reg;
                mul_next   = mul_res;
                state_next = ST_SEED_M2;
            end
            ST_SEED_M2:
            begin
                mul_a      = seed_mix[31:0];
                mul_b      = SEED_MULT[63:32];
                acc_next   = acc_reg + {mul_reg[31:0], 32'b0};
                mul_next   = mul_res;
                state_next = ST_SEED_M3;
            end
            ST_SEED_M3:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = acc_reg + {mul_reg[31:0], 32'b0}
                          + {{(WORD_BITS-ADDR_BITS){1'b0}}, cnt_reg};
                prev_next = mem_wdata;
                if (cnt_reg == LAST_WORD)
                begin
                    index_next = USED_UP;
                    state_next = extract_reg ? ST_TW_PRIME : ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_plus1;
                    state_next = ST_SEED_M0;
                end
            end
            ST_TW_PRIME:
            begin
                // fetch word zero so the first step has its upper bits
                rd_en      = 1'b1;
                rd_addr_a  = '0;
                cnt_next   = '0;
                state_next = ST_TW_RD;
            end
            ST_TW_RD:
            begin
                if (cnt_reg == '0)
                begin
                    carry_next = rd_a_q;
                end
                rd_en      = 1'b1;
                rd_addr_a  = addr_succ;
                rd_addr_b  = addr_mid;
                state_next = ST_TW_WR;
            end
            ST_TW_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cnt_reg;
                mem_wdata  = rd_b_q ^ twist_v;
                carry_next = rd_a_q;
                if (cnt_reg == LAST_WORD)
                begin
                    index_next = '0;
                    state_next = ST_EX_RD;
                end
                else
                begin
                    cnt_next   = cnt_plus1;
                    state_next = ST_TW_RD;
                end
            end
            ST_EX_RD:
            begin
                rd_en      = 1'b1;
                rd_addr_a  = index_reg;
                state_next = ST_EX_OUT;
            end
            ST_EX_OUT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = temper(rd_a_q);
                    index_next     = index_reg + addr_t'(1);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            index_reg     <= NEVER_SEEDED;
            cnt_reg       <= '0;
            extract_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            index_reg     <= index_next;
            cnt_reg       <= cnt_next;
            extract_reg   <= extract_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        carry_reg    <= carry_next;
        acc_reg      <= acc_next;
        mul_reg      <= mul_next;
        out_word_reg <= out_word_next;
    end

    `MT64_ASSERT_NOW(a_extract_index_in_range, state_reg == ST_EX_RD, index_reg < USED_UP, "extract read with an exhausted or unseeded index")
    `MT64_ASSERT_NEXT(a_twist_restarts_index, (state_reg == ST_TW_WR) && (cnt_reg == LAST_WORD), index_reg == '0, "twist end did not restart the word index")
    `MT64_ASSERT_NEXT(a_seed_marks_used_up, (state_reg == ST_SEED_M3) && (cnt_reg == LAST_WORD), index_reg == USED_UP, "seed end did not mark the state for a twist")
    `MT64_ASSERT_NOW(a_result_from_extract, $rose(out_valid_reg), $past(state_reg) == ST_EX_OUT, "result appeared outside the extract step")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top import mt64_pkg::*; ();

    localparam int          RANDOM_ITEMS = 1930;
    localparam int          SWAP_AT      = 650;
    localparam int          QUIET_AT     = 1300;
    localparam int          DRAIN_CYCLES = 1400;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam word_t       ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam word_t       LOW_MASK     = 64'h0000_0000_7FFF_FFFF;
    // First output of the default seed, as published for this scheme
    localparam word_t       DEFAULT_FIRST_WORD = 64'hC96D_191C_F6F6_AEA6;

    typedef struct packed {
        logic  func;
        word_t seed_value;
        bit    typed;
        word_t random_word;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 18;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{FUNC_EXTRACT, 64'h0,                   1'b1, DEFAULT_FIRST_WORD},
        '{FUNC_EXTRACT, 64'h0,                   1'b0, 64'h0},
        '{FUNC_SEED,    64'h0,                   1'b0, 64'h0},
        '{FUNC_EXTRACT, 64'h0,                   1'b0, 64'h0},
        '{FUNC_EXTRACT, ALL_ONES,                1'b0, 64'h0},
        '{FUNC_SEED,    ALL_ONES,                1'b0, 64'h0},
        '{FUNC_EXTRACT, 64'h0,                   1'b0, 64'h0},
        '{FUNC_SEED,    DEFAULT_SEED,            1'b0, 64'h0},
        '{FUNC_EXTRACT, 64'h0,                   1'b1, DEFAULT_FIRST_WORD},
        '{FUNC_SEED,    64'h1,                   1'b0, 64'h0},
        '{FUNC_SEED,    64'h8000_0000_0000_0000, 1'b0, 64'h0},
        '{FUNC_EXTRACT, 64'h0,                   1'b0, 64'h0},
        '{FUNC_SEED,    64'h5555_5555_5555_5555, 1'b0, 64'h0},
        '{FUNC_EXTRACT, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
        '{FUNC_SEED,    64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
        '{FUNC_EXTRACT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
        '{FUNC_EXTRACT, ALL_ONES,                1'b0, 64'h0},
        '{FUNC_EXTRACT, 64'h0,                   1'b0, 64'h0}
    };

    logic clk;
    logic rst_n;

    mt64_req_if req ();
    mt64_rsp_if rsp ();

    mersenne_twister_64_generator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    word_t       mt_words [STATE_WORDS];
    int unsigned mt_pos;
    word_t       pending_words [$];
    int          errors;
    int          sent;
    int          send_idle;
    int          rcv_idle;
    int unsigned cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void fill_words(input word_t s);
        word_t p;
        int    i;
        mt_words[0] = s;
        for (i = 1; i < STATE_WORDS; i++)
        begin
            p = mt_words[i-1];
            mt_words[i] = SEED_MULT * (p ^ (p >> (WORD_BITS - 2))) + word_t'(i);
        end
        mt_pos = STATE_WORDS;
    endfunction

    function automatic void regenerate_words();
        word_t x;
        word_t v;
        int    i;
        for (i = 0; i < STATE_WORDS; i++)
        begin
            x = (mt_words[i] & ~LOW_MASK) | (mt_words[(i + 1) % STATE_WORDS] & LOW_MASK);
            v = x >> 1;
            if (x[0])
                v = v ^ TWIST_MATRIX;
            mt_words[i] = mt_words[(i + MIDDLE_OFFSET) % STATE_WORDS] ^ v;
        end
        mt_pos = 0;
    endfunction

    function automatic word_t scrambled(input word_t w);
        word_t y;
        y = w;
        y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
        y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
        y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
        y = y ^ (y >> 43);
        return y;
    endfunction

    function automatic word_t next_random_word();
        word_t y;
        if (mt_pos >= STATE_WORDS)
        begin
            // never seeded: fall back to the default seed first
            if (mt_pos > STATE_WORDS)
                fill_words(DEFAULT_SEED);
            regenerate_words();
        end
        y = scrambled(mt_words[mt_pos % STATE_WORDS]);
        mt_pos = mt_pos + 1;
        return y;
    endfunction

    function automatic word_t pick_seed();
        case ($urandom_range(0, 7))
            0:       return 64'h0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_request(input logic f, input word_t s, input bit typed,
                                input word_t typed_word);
        word_t w;
        while ($urandom_range(0, 99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.func       <= f;
        req.seed_value <= s;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (f == FUNC_SEED)
        begin
            fill_words(s);
        end
        else
        begin
            w = next_random_word();
            pending_words.push_back(typed ? typed_word : w);
        end
        sent++;
        // swap the idle pattern, then run without idling
        if (sent == SWAP_AT)
        begin
            send_idle = 83;
            rcv_idle  = 26;
        end
        else if (sent == QUIET_AT)
        begin
            send_idle = 0;
            rcv_idle  = 0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t: random_word expected none, got %h", $time, rsp.random_word);
                    errors++;
                end
                else
                begin
                    if (rsp.random_word !== pending_words[0])
                    begin
                        $display("%0t: random_word expected %h, got %h", $time,
                                 pending_words[0], rsp.random_word);
                        errors++;
                    end
                    void'(pending_words.pop_front());
                end
            end
            rsp.ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
        else
        begin
            rsp.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int n;
        int burst;
        req.valid      = 1'b0;
        req.func       = FUNC_SEED;
        req.seed_value = '0;
        rst_n          = 1'b0;
        errors         = 0;
        sent           = 0;
        send_idle      = 26;
        rcv_idle       = 83;
        mt_pos         = NEVER_SEEDED;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIRECTED_ROWS; n++)
            send_request(directed_rows[n].func, directed_rows[n].seed_value,
                         directed_rows[n].typed, directed_rows[n].random_word);

        // optional reseeds, then bursts of extracts, often long enough to use up every word
        while (sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_request(FUNC_SEED, pick_seed(), 1'b0, 64'h0);
                if ($urandom_range(0, 4) == 0)
                    send_request(FUNC_SEED, pick_seed(), 1'b0, 64'h0);
            end
            if ($urandom_range(0, 3) == 0)
                burst = $urandom_range(300, 650);
            else
                burst = $urandom_range(1, 40);
            // stop the last burst at the request budget
            repeat (burst)
                if (sent < DIRECTED_ROWS + RANDOM_ITEMS)
                    send_request(FUNC_EXTRACT, {$urandom, $urandom}, 1'b0, 64'h0);
        end
        req.valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
